/* rtl/apt_pkg.sv */
// Shared types, widths and helper functions of the affine point transform.
`default_nettype none
package apt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 24;
    localparam int DW        = 32;
    localparam int OW        = DW + 1;
    localparam int PW        = CW + OW;
    localparam int SW        = PW + 2;
    localparam int DETW      = 2 * CW + 1;
    localparam int QW        = DW + 1;
    localparam int RW        = DETW + QW;
    localparam int MW        = SW + 1 - FRAC_BITS;
    localparam int CFG_IW    = 3;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_INV = 1'b1;

    localparam logic [CFG_IW-1:0] REG_COEF_A   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COEF_B   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_COEF_C   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_COEF_D   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_OFFSET_X = 3'd4;
    localparam logic [CFG_IW-1:0] REG_OFFSET_Y = 3'd5;

    localparam logic [MW-1:0] POS_LIM = MW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [MW-1:0] NEG_LIM = MW'(64'd1 << (DW - 1));

    typedef struct packed {
        logic                 kind;
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
    } apt_op_t;

    typedef struct packed {
        logic          ovf;
        logic [DW-1:0] val;
    } apt_sat_t;

    typedef struct packed {
        logic     kind;
        logic     sing;
        logic     neg_x;
        logic     neg_y;
        apt_sat_t fx;
        apt_sat_t fy;
    } apt_side_t;

    function automatic apt_sat_t sat_mag(input logic neg, input logic [MW-1:0] m,
                                         input logic big);
        apt_sat_t r;
        r.ovf = 1'b0;
        if (neg) begin
            if (big || m > NEG_LIM) begin
                r.ovf = 1'b1;
                r.val = NEG_LIM[DW-1:0];
            end else begin
                r.val = DW'(~m[DW-1:0] + 1'b1);
            end
        end else begin
            if (big || m > POS_LIM) begin
                r.ovf = 1'b1;
                r.val = POS_LIM[DW-1:0];
            end else begin
                r.val = m[DW-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] s);
        return s[SW-1] ? SW'(-s) : SW'(s);
    endfunction

endpackage
`default_nettype wire

/* rtl/apt_front.sv */
// Front end: accepts points, removes offsets for inverse words and holds one word for the queue.
`default_nettype none
module apt_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic                          in_kind,
    input  wire logic signed [apt_pkg::DW-1:0] in_x,
    input  wire logic signed [apt_pkg::DW-1:0] in_y,
    input  wire logic signed [apt_pkg::DW-1:0] offset_x,
    input  wire logic signed [apt_pkg::DW-1:0] offset_y,
    input  wire logic                          q_full,
    output logic                               push,
    output apt_pkg::apt_op_t                   op
);
    logic             f_valid_reg, f_valid_next;
    apt_pkg::apt_op_t op_reg, op_next;
    logic             accept;

    assign s_tready = !f_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = f_valid_reg && !q_full;
    assign op       = op_reg;

    always_comb begin
        op_next.kind = in_kind;
        if (in_kind == apt_pkg::KIND_INV) begin
            op_next.ox = apt_pkg::OW'(in_x) - apt_pkg::OW'(offset_x);
            op_next.oy = apt_pkg::OW'(in_y) - apt_pkg::OW'(offset_y);
        end else begin
            op_next.ox = apt_pkg::OW'(in_x);
            op_next.oy = apt_pkg::OW'(in_y);
        end
        f_valid_next = f_valid_reg;
        if (accept) begin
            f_valid_next = 1'b1;
        end else if (push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        if (accept) begin
            op_reg <= op_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/apt_queue.sv */
// Short first-in first-out queue between the front and back ends.
`default_nettype none
module apt_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire apt_pkg::apt_op_t  wr_op,
    input  wire logic              pop,
    output apt_pkg::apt_op_t       rd_op,
    output logic                   full,
    output logic                   empty
);
    apt_pkg::apt_op_t            mem_reg [apt_pkg::QDEPTH];
    logic [apt_pkg::QAW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [apt_pkg::QAW:0]       count_reg, count_next;

    assign full  = count_reg == (apt_pkg::QAW+1)'(apt_pkg::QDEPTH);
    assign empty = count_reg == '0;
    assign rd_op = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end
endmodule
`default_nettype wire

/* rtl/apt_div.sv */
// Pipelined restoring divider giving a rounded-to-be quotient with one bit per stage.
`default_nettype none
module apt_div (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [apt_pkg::SW-1:0]   num,
    input  wire logic [apt_pkg::DETW-1:0] den,
    output logic [apt_pkg::QW-1:0]        quo,
    output logic                          big
);
    logic [apt_pkg::RW-1:0]   rem_reg [apt_pkg::QW+1];
    logic [apt_pkg::DETW-1:0] den_reg [apt_pkg::QW+1];
    logic [apt_pkg::QW-1:0]   quo_reg [apt_pkg::QW+1];
    logic                     big_reg [apt_pkg::QW+1];
    logic [apt_pkg::RW-1:0]   rem0;

    assign rem0 = apt_pkg::RW'(num) << (apt_pkg::FRAC_BITS + 1);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem0;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            big_reg[0] <= rem0 >= (apt_pkg::RW'(den) << apt_pkg::QW);
        end
    end

    for (genvar i = 1; i <= apt_pkg::QW; i++) begin : g_stage
        logic [apt_pkg::RW-1:0] dk;
        logic                   ge;
        assign dk = apt_pkg::RW'(den_reg[i-1]) << (apt_pkg::QW - i);
        assign ge = rem_reg[i-1] >= dk;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? rem_reg[i-1] - dk : rem_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                big_reg[i] <= big_reg[i-1];
                quo_reg[i] <= quo_reg[i-1]
                    | (apt_pkg::QW'(ge) << (apt_pkg::QW - i));
            end
        end
    end

    assign quo = quo_reg[apt_pkg::QW];
    assign big = big_reg[apt_pkg::QW];
endmodule
`default_nettype wire

/* rtl/apt_back.sv */
// Back end: products, sums, rounding, division and the output register.
`default_nettype none
module apt_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          empty,
    input  wire apt_pkg::apt_op_t              rd_op,
    output logic                               pop,
    input  wire logic signed [apt_pkg::CW-1:0] coef_a,
    input  wire logic signed [apt_pkg::CW-1:0] coef_b,
    input  wire logic signed [apt_pkg::CW-1:0] coef_c,
    input  wire logic signed [apt_pkg::CW-1:0] coef_d,
    input  wire logic signed [apt_pkg::DW-1:0] offset_x,
    input  wire logic signed [apt_pkg::DW-1:0] offset_y,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [apt_pkg::DW-1:0]             out_x,
    output logic [apt_pkg::DW-1:0]             out_y,
    output logic                               singular,
    output logic                               overflow
);
    localparam int L = apt_pkg::QW;

    logic                              adv;
    logic                              v1_reg, v2_reg, v3_reg;
    apt_pkg::apt_op_t                  op1_reg;
    logic                              k2_reg, k3_reg;
    logic signed [apt_pkg::PW-1:0]     p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [apt_pkg::SW-1:0]     s0_reg, s1_reg, s0_next, s1_next;
    logic signed [2*apt_pkg::CW-1:0]   pad_reg, pcb_reg;
    logic signed [apt_pkg::DETW-1:0]   det_reg;
    logic signed [apt_pkg::CW-1:0]     m0, m3;
    logic [apt_pkg::SW-1:0]            mag0, mag1;
    logic [apt_pkg::DETW-1:0]          det_mag;
    logic                              sv_reg [L+1];
    apt_pkg::apt_side_t                side_reg [L+1];
    apt_pkg::apt_side_t                side_next;
    logic [apt_pkg::QW-1:0]            qx, qy;
    logic                              bx, by;
    apt_pkg::apt_sat_t                 rx, ry;
    apt_pkg::apt_side_t                sl;
    logic                              ov_reg, sg_reg, mv_reg;
    logic [apt_pkg::DW-1:0]            ox_reg, oy_reg;

    assign adv = !mv_reg || m_tready;
    assign pop = adv && !empty;

    always_ff @(posedge aclk) begin
        pad_reg <= coef_a * coef_d;
        pcb_reg <= coef_c * coef_b;
        det_reg <= apt_pkg::DETW'(pad_reg) - apt_pkg::DETW'(pcb_reg);
    end

    assign m0 = (op1_reg.kind == apt_pkg::KIND_INV) ? coef_d : coef_a;
    assign m3 = (op1_reg.kind == apt_pkg::KIND_INV) ? coef_a : coef_d;

    always_comb begin
        if (k2_reg == apt_pkg::KIND_INV) begin
            s0_next = apt_pkg::SW'(p0_reg) - apt_pkg::SW'(p1_reg);
            s1_next = apt_pkg::SW'(p3_reg) - apt_pkg::SW'(p2_reg);
        end else begin
            s0_next = apt_pkg::SW'(p0_reg) + apt_pkg::SW'(p1_reg)
                    + (apt_pkg::SW'(offset_x) <<< apt_pkg::FRAC_BITS);
            s1_next = apt_pkg::SW'(p2_reg) + apt_pkg::SW'(p3_reg)
                    + (apt_pkg::SW'(offset_y) <<< apt_pkg::FRAC_BITS);
        end
    end

    assign mag0    = apt_pkg::mag_of(s0_reg);
    assign mag1    = apt_pkg::mag_of(s1_reg);
    assign det_mag = det_reg[apt_pkg::DETW-1] ? apt_pkg::DETW'(-det_reg)
                                              : apt_pkg::DETW'(det_reg);

    always_comb begin
        side_next.kind  = k3_reg;
        side_next.sing  = det_reg == '0;
        side_next.neg_x = s0_reg[apt_pkg::SW-1] != det_reg[apt_pkg::DETW-1];
        side_next.neg_y = s1_reg[apt_pkg::SW-1] != det_reg[apt_pkg::DETW-1];
        side_next.fx    = apt_pkg::sat_mag(s0_reg[apt_pkg::SW-1],
            apt_pkg::MW'(({1'b0, mag0} + (apt_pkg::SW+1)'(1 << (apt_pkg::FRAC_BITS-1)))
                >> apt_pkg::FRAC_BITS), 1'b0);
        side_next.fy    = apt_pkg::sat_mag(s1_reg[apt_pkg::SW-1],
            apt_pkg::MW'(({1'b0, mag1} + (apt_pkg::SW+1)'(1 << (apt_pkg::FRAC_BITS-1)))
                >> apt_pkg::FRAC_BITS), 1'b0);
    end

    apt_div u_div_x (.aclk(aclk), .en(adv), .num(mag0), .den(det_mag), .quo(qx), .big(bx));
    apt_div u_div_y (.aclk(aclk), .en(adv), .num(mag1), .den(det_mag), .quo(qy), .big(by));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i <= L; i++) begin
                sv_reg[i] <= 1'b0;
            end
            mv_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= pop;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            sv_reg[0] <= v3_reg;
            for (int i = 1; i <= L; i++) begin
                sv_reg[i] <= sv_reg[i-1];
            end
            mv_reg <= sv_reg[L];
        end
        if (adv) begin
            op1_reg     <= rd_op;
            k2_reg      <= op1_reg.kind;
            p0_reg      <= m0 * op1_reg.ox;
            p1_reg      <= coef_b * op1_reg.oy;
            p2_reg      <= coef_c * op1_reg.ox;
            p3_reg      <= m3 * op1_reg.oy;
            k3_reg      <= k2_reg;
            s0_reg      <= s0_next;
            s1_reg      <= s1_next;
            side_reg[0] <= side_next;
            for (int i = 1; i <= L; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            ox_reg <= sl.kind ? (sl.sing ? '0 : rx.val) : sl.fx.val;
            oy_reg <= sl.kind ? (sl.sing ? '0 : ry.val) : sl.fy.val;
            sg_reg <= sl.kind && sl.sing;
            ov_reg <= sl.kind ? (!sl.sing && (rx.ovf || ry.ovf))
                              : (sl.fx.ovf || sl.fy.ovf);
        end
    end

    assign sl = side_reg[L];
    assign rx = apt_pkg::sat_mag(sl.neg_x,
        apt_pkg::MW'(({1'b0, qx} + 1'b1) >> 1), bx);
    assign ry = apt_pkg::sat_mag(sl.neg_y,
        apt_pkg::MW'(({1'b0, qy} + 1'b1) >> 1), by);

    assign m_tvalid = mv_reg;
    assign out_x    = ox_reg;
    assign out_y    = oy_reg;
    assign singular = sg_reg;
    assign overflow = ov_reg;
endmodule
`default_nettype wire

/* rtl/affine_point_transform.sv */
// Top level of the affine point transform: configuration registers and the two ends.
// Maps one signed Q16.16 point per word through the matrix [a b; c d] plus an offset.
// Input words arrive on the s_ channel: tdata holds x (low half) and y (high half),
// tuser holds the kind (forward when low, inverse when high).
// Results leave on the m_ channel: tdata holds the transformed x and y in the same
// order, tuser holds the singular flag (bit 0) and the overflow flag (bit 1).
// One word is accepted every cycle while s_tready is high; each passes the front
// register, the queue, the product and sum stages, one stage per quotient bit of the
// 33-bit pipelined divider, which forward words also pass through to keep order.
// The user must write coefficients and offsets (cfg_wr_en, cfg_index, cfg_wdata)
// only while no word is in flight; the block does not enforce it. Unknown indices are
// ignored. Reset loads the identity matrix with no offset and empties the pipeline.
// With m_tvalid high and m_tready held low the whole back end stops, the four-entry
// queue fills and then s_tready falls; no word is lost or repeated.
`default_nettype none
module affine_point_transform (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,   // in_x, in_y
    input  wire logic                           s_tuser,   // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata,   // out_x, out_y
    output logic [1:0]                          m_tuser,   // singular, overflow
    input  wire logic                           cfg_wr_en,
    input  wire logic [apt_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [apt_pkg::DW-1:0]         cfg_wdata
);
    logic signed [apt_pkg::CW-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic signed [apt_pkg::DW-1:0] offset_x_reg, offset_y_reg;
    logic                          q_full, q_empty, push, pop;
    apt_pkg::apt_op_t              wr_op, rd_op;
    logic [apt_pkg::DW-1:0]        out_x, out_y;
    logic                          singular, overflow;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a_reg   <= apt_pkg::CW'(1 << apt_pkg::FRAC_BITS);
            coef_b_reg   <= '0;
            coef_c_reg   <= '0;
            coef_d_reg   <= apt_pkg::CW'(1 << apt_pkg::FRAC_BITS);
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                apt_pkg::REG_COEF_A:   coef_a_reg   <= cfg_wdata[apt_pkg::CW-1:0];
                apt_pkg::REG_COEF_B:   coef_b_reg   <= cfg_wdata[apt_pkg::CW-1:0];
                apt_pkg::REG_COEF_C:   coef_c_reg   <= cfg_wdata[apt_pkg::CW-1:0];
                apt_pkg::REG_COEF_D:   coef_d_reg   <= cfg_wdata[apt_pkg::CW-1:0];
                apt_pkg::REG_OFFSET_X: offset_x_reg <= cfg_wdata;
                apt_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    apt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_kind(s_tuser), .in_x(s_tdata[31:0]), .in_y(s_tdata[63:32]),
        .offset_x(offset_x_reg), .offset_y(offset_y_reg),
        .q_full(q_full), .push(push), .op(wr_op)
    );

    apt_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push), .wr_op(wr_op),
        .pop(pop), .rd_op(rd_op), .full(q_full), .empty(q_empty)
    );

    apt_back u_back (
        .aclk(aclk), .aresetn(aresetn), .empty(q_empty), .rd_op(rd_op), .pop(pop),
        .coef_a(coef_a_reg), .coef_b(coef_b_reg), .coef_c(coef_c_reg),
        .coef_d(coef_d_reg), .offset_x(offset_x_reg), .offset_y(offset_y_reg),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .out_x(out_x), .out_y(out_y),
        .singular(singular), .overflow(overflow)
    );

    assign m_tdata = {out_y, out_x};
    assign m_tuser = {overflow, singular};
endmodule
`default_nettype wire

/* rtl/apt_checker.sv */
// Port checker for the affine point transform, bound to the top level.
`default_nettype none
module apt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result word withdrawn while stalled.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result word shown straight after reset.");

    a_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1])
        else $error("Singular result is not zero or claims overflow.");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000 ||
            m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000)
        else $error("Overflow flagged without a clamped coordinate.");
endmodule

bind affine_point_transform apt_checker u_apt_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
